FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the pendulum controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSBC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("psbc assertion failed");
`define PSBC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psbc assertion failed");
`define PSBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psbc assertion failed");
`else
`define PSBC_ASSERT(lbl, prop)
`define PSBC_ASSERT_IMPL(lbl, ante, cons)
`define PSBC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/psbc_pkg.sv
// Package: constants, widths and types of the pendulum controller
package psbc_pkg;
	localparam int PI_Q12      = 12868;
	localparam int HALF_PI_Q12 = 6434;
	localparam int TWO_PI_Q12  = 25736;
	localparam int ONE_Q14     = 16384;
	localparam int INTEG_LIMIT = 8192000;
	localparam int BAL_DIV     = 131072000;
	localparam int SWING_DIV   = 419430400;
	localparam int COS_DIV1    = 56;
	localparam int COS_DIV2    = 30 * ONE_Q14;
	localparam int COS_DIV3    = 12 * ONE_Q14;

	localparam int MUL_AW = 40;
	localparam int MUL_BW = 17;
	localparam int ACC_W  = 58;
	localparam int DIV_NW = 58;
	localparam int DIV_DW = 30;
	localparam int E24_W  = 34;
	localparam int INTEG_W = 26;

	localparam int ANGLE_OFFSET_DEF   = 0;
	localparam int OUTPUT_SIGN_DEF    = 1;
	localparam int POTENTIAL_COEF_DEF = 1990;
	localparam int KINETIC_COEF_DEF   = 1116;

	localparam int TERMS_BAL   = 5;
	localparam int TERMS_SWING = 3;

	typedef enum logic [2:0] {
		REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN, REG_ARM_GAIN,
		REG_ARM_DAMP_GAIN, REG_PUMP_GAIN, REG_CATCH_ANGLE, REG_DRIVE_LIMIT
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WRAP, ST_SEL, ST_COS_SQ, ST_COS_D1, ST_COS_M2, ST_COS_D2,
		ST_COS_M3, ST_COS_D3, ST_COS_M4, ST_EN_SQ, ST_EN_K, ST_EN_P, ST_TERM,
		ST_ROUND, ST_OUT
	} ctl_state_t;
endpackage

FILE: rtl/core/psbc_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle
module psbc_smul #(
	parameter int AW = psbc_pkg::MUL_AW,
	parameter int BW = psbc_pkg::MUL_BW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [AW-1:0]  a,
	input  logic [BW-1:0]  b,
	output logic           done,
	output logic [AW+BW-1:0] p
);
	localparam int CW = $clog2(BW + 1);

	logic [AW+BW-1:0] p_q;
	logic [AW-1:0]    a_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [AW:0]      sum;

	assign sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(BW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{AW{1'b0}}, b};
			a_q <= a;
		end else if (cnt_q != '0) begin
			p_q <= {sum, p_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = p_q;
endmodule

FILE: rtl/core/psbc_sdiv.sv
// Restoring divider, one quotient bit per cycle
module psbc_sdiv #(
	parameter int NW = psbc_pkg::DIV_NW,
	parameter int DW = psbc_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   r2;
	logic [DW:0]   diff;
	logic          ge;

	assign r2   = {rem_q, n_q[NW-1]};
	assign ge   = r2 >= {1'b0, d_q};
	assign diff = r2 - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DW-1:0] : r2[DW-1:0];
			n_q   <= {n_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = n_q;
	assign rem  = rem_q;
endmodule

FILE: rtl/core/pendulum_swingup_balance_control.sv
// Top level: sequencer of the swing-up and balance pendulum controller
// One sample per transfer; the first sample after reset only primes the block.
// A sample is worked through one shared bit-serial multiplier (start, 17 shifts,
// done per product) and one restoring divider (start, 58 shifts, done per
// quotient), in turn: angle wrap, five gain products and final rounding in
// balance mode; wrap, polynomial cosine, energy, three products and rounding in
// swing-up mode, and only then is the next sample taken. The result waits in
// an output register, so the next sample is taken while it is still unread;
// a sample stalls at the end only when an earlier result has not yet left.
module pendulum_swingup_balance_control #(
	parameter int ANGLE_OFFSET   = psbc_pkg::ANGLE_OFFSET_DEF,
	parameter int OUTPUT_SIGN    = psbc_pkg::OUTPUT_SIGN_DEF,
	parameter int POTENTIAL_COEF = psbc_pkg::POTENTIAL_COEF_DEF,
	parameter int KINETIC_COEF   = psbc_pkg::KINETIC_COEF_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// arm_angle[15:0], pendulum_angle[47:16], arm_speed[63:48], pendulum_speed[79:64]
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// drive_voltage[15:0]
	output logic [15:0] m_axis_tdata,
	// balancing[0]
	output logic [0:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import psbc_pkg::*;
	`include "assert_macros.svh"

	ctl_state_t state_q, state_n;

	logic [15:0] kp_q, ki_q, kd_q, ka_q, kad_q, kpump_q;
	logic [13:0] catch_q;
	logic [14:0] lim_q;

	logic run_q, primed_q;
	logic signed [15:0] arm_q, aspd_q, ps_q, alpha_q, last_q;
	logic signed [31:0] raw_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic bal_q, cneg_q, pneg_q;
	logic [15:0] x_q, y_q;
	logic [14:0] t_q;
	logic signed [16:0] c_q;
	logic [MUL_AW+MUL_BW-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [E24_W-1:0] e24_q;
	logic [2:0] tix_q;
	logic [15:0] v_q;
	logic m_tvalid_q, mode_q;
	logic [15:0] dv_q;

	logic accept;
	logic mul_start, mul_done, div_start, div_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_AW+MUL_BW-1:0] mul_p;
	logic [DIV_NW-1:0] div_num, div_quot;
	logic [DIV_DW-1:0] div_den, div_rem;

	// magnitudes of the sample
	logic signed [16:0] arm17, aspd17, ps17, err17;
	logic [16:0] armm, aspdm, psm, errm;
	logic [INTEG_W-1:0] isumm;
	logic [E24_W-1:0] e24m;

	// angle wrap
	logic signed [33:0] wrap_t;
	logic [33:0] wrap_mag;
	logic [15:0] wrap_r;
	logic signed [15:0] alpha_n;

	// mode select
	logic [13:0] amag, cm;
	logic bal_n;
	logic signed [INTEG_W:0] isum_raw;
	logic signed [INTEG_W-1:0] integ_n;

	logic term_neg, last_term;
	logic signed [17:0] ec;
	logic signed [ACC_W-1:0] acc_n;
	logic [ACC_W-1:0] accm;
	logic [29:0] rdiv;
	logic [14:0] qc;
	logic out_neg;
	logic [14:0] q4;
	logic signed [16:0] tt;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	assign arm17  = 17'(arm_q);
	assign aspd17 = 17'(aspd_q);
	assign ps17   = 17'(ps_q);
	assign err17  = -17'(alpha_q);
	assign armm   = arm17[16]  ? 17'(-arm17)  : 17'(arm17);
	assign aspdm  = aspd17[16] ? 17'(-aspd17) : 17'(aspd17);
	assign psm    = ps17[16]   ? 17'(-ps17)   : 17'(ps17);
	assign errm   = err17[16]  ? 17'(-err17)  : 17'(err17);
	assign isumm  = integ_q[INTEG_W-1] ? INTEG_W'(-integ_q) : INTEG_W'(integ_q);
	assign e24m   = e24_q[E24_W-1] ? E24_W'(-e24_q) : E24_W'(e24_q);

	assign wrap_t   = 34'(raw_q) - 34'(ANGLE_OFFSET) + 34'(PI_Q12);
	assign wrap_mag = wrap_t[33] ? 34'(-wrap_t) : 34'(wrap_t);
	assign wrap_r   = (wrap_t[33] && div_rem[15:0] != '0) ?
		16'(TWO_PI_Q12) - div_rem[15:0] : div_rem[15:0];
	assign alpha_n  = signed'(wrap_r - 16'(PI_Q12));

	assign amag  = alpha_q[15] ? 14'(-alpha_q) : 14'(alpha_q);
	assign bal_n = amag <= catch_q;
	assign cm    = (amag > 14'(HALF_PI_Q12)) ? 14'(PI_Q12) - amag : amag;
	assign isum_raw = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err17) + (INTEG_W+1)'(last_q);
	always_comb begin
		if (isum_raw > (INTEG_W+1)'(INTEG_LIMIT)) begin
			integ_n = INTEG_W'(INTEG_LIMIT);
		end else if (isum_raw < -(INTEG_W+1)'(INTEG_LIMIT)) begin
			integ_n = -INTEG_W'(INTEG_LIMIT);
		end else begin
			integ_n = INTEG_W'(isum_raw);
		end
	end

	assign ec    = 18'(ONE_Q14) - 18'(c_q);
	assign q4    = mul_p[29:15];
	assign tt    = 17'(ONE_Q14) - 17'(q4);
	assign acc_n = acc_q + (term_neg ? -ACC_W'(mul_p) : ACC_W'(mul_p));
	assign accm  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign rdiv  = bal_q ? 30'(BAL_DIV) : 30'(SWING_DIV);
	assign qc    = (div_quot > DIV_NW'(lim_q)) ? lim_q : div_quot[14:0];
	assign out_neg = acc_q[ACC_W-1] ^ (OUTPUT_SIGN < 0);
	assign last_term = bal_q ? (tix_q == 3'(TERMS_BAL - 1)) : (tix_q == 3'(TERMS_SWING - 1));

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		term_neg = 1'b0;
		unique case (state_q)
			ST_COS_SQ: begin
				mul_a = MUL_AW'(x_q);
				mul_b = MUL_BW'(x_q);
			end
			ST_COS_M2, ST_COS_M3, ST_COS_M4: begin
				mul_a = MUL_AW'(y_q);
				mul_b = MUL_BW'(t_q);
			end
			ST_EN_SQ: begin
				mul_a = MUL_AW'(psm);
				mul_b = psm;
			end
			ST_EN_K: begin
				mul_a = MUL_AW'(prod_q[30:0]);
				mul_b = MUL_BW'(KINETIC_COEF);
			end
			ST_EN_P: begin
				mul_a = MUL_AW'(ec[16:0]) << 10;
				mul_b = MUL_BW'(POTENTIAL_COEF);
			end
			ST_TERM: begin
				if (bal_q) begin
					unique case (tix_q)
						3'd0: begin
							mul_a = MUL_AW'(errm) * MUL_AW'(2000);
							mul_b = MUL_BW'(kp_q);
							term_neg = err17[16];
						end
						3'd1: begin
							mul_a = MUL_AW'(isumm);
							mul_b = MUL_BW'(ki_q);
							term_neg = integ_q[INTEG_W-1];
						end
						3'd2: begin
							mul_a = MUL_AW'(psm) * MUL_AW'(32000);
							mul_b = MUL_BW'(kd_q);
							term_neg = !ps17[16];
						end
						3'd3: begin
							mul_a = MUL_AW'(armm) * MUL_AW'(2000);
							mul_b = MUL_BW'(ka_q);
							term_neg = !arm17[16];
						end
						default: begin
							mul_a = MUL_AW'(aspdm) * MUL_AW'(32000);
							mul_b = MUL_BW'(kad_q);
							term_neg = !aspd17[16];
						end
					endcase
				end else begin
					unique case (tix_q)
						3'd0: begin
							mul_a = MUL_AW'(e24m) * MUL_AW'(25);
							mul_b = MUL_BW'(kpump_q);
							term_neg = !(pneg_q ^ e24_q[E24_W-1]);
						end
						3'd1: begin
							mul_a = MUL_AW'(armm) * MUL_AW'(6400);
							mul_b = MUL_BW'(ka_q);
							term_neg = arm17[16];
						end
						default: begin
							mul_a = MUL_AW'(aspdm) << 10;
							mul_b = MUL_BW'(kad_q);
							term_neg = aspd17[16];
						end
					endcase
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_num = '0;
		div_den = '0;
		unique case (state_q)
			ST_WRAP: begin
				div_num = DIV_NW'(wrap_mag);
				div_den = DIV_DW'(TWO_PI_Q12);
			end
			ST_COS_D1: begin
				div_num = DIV_NW'(y_q);
				div_den = DIV_DW'(COS_DIV1);
			end
			ST_COS_D2: begin
				div_num = DIV_NW'(prod_q);
				div_den = DIV_DW'(COS_DIV2);
			end
			ST_COS_D3: begin
				div_num = DIV_NW'(prod_q);
				div_den = DIV_DW'(COS_DIV3);
			end
			ST_ROUND: begin
				div_num = accm + DIV_NW'(rdiv >> 1);
				div_den = rdiv;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && primed_q) state_n = ST_WRAP;
			ST_WRAP:   if (div_done) state_n = ST_SEL;
			ST_SEL:    state_n = bal_n ? ST_TERM : ST_COS_SQ;
			ST_COS_SQ: if (mul_done) state_n = ST_COS_D1;
			ST_COS_D1: if (div_done) state_n = ST_COS_M2;
			ST_COS_M2: if (mul_done) state_n = ST_COS_D2;
			ST_COS_D2: if (div_done) state_n = ST_COS_M3;
			ST_COS_M3: if (mul_done) state_n = ST_COS_D3;
			ST_COS_D3: if (div_done) state_n = ST_COS_M4;
			ST_COS_M4: if (mul_done) state_n = ST_EN_SQ;
			ST_EN_SQ:  if (mul_done) state_n = ST_EN_K;
			ST_EN_K:   if (mul_done) state_n = ST_EN_P;
			ST_EN_P:   if (mul_done) state_n = ST_TERM;
			ST_TERM:   if (mul_done && last_term) state_n = ST_ROUND;
			ST_ROUND:  if (div_done) state_n = ST_OUT;
			ST_OUT:    if (!m_tvalid_q || m_axis_tready) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// unit starts
	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_COS_SQ, ST_COS_M2, ST_COS_M3, ST_COS_M4, ST_EN_SQ, ST_EN_K,
			ST_EN_P, ST_TERM: mul_start = !run_q;
			ST_WRAP, ST_COS_D1, ST_COS_D2, ST_COS_D3, ST_ROUND: div_start = !run_q;
			default: begin
				mul_start = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_q      <= 1'b0;
			primed_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			kp_q       <= 16'd40960;
			ki_q       <= 16'd2048;
			kd_q       <= 16'd410;
			ka_q       <= 16'd205;
			kad_q      <= 16'd41;
			kpump_q    <= 16'd12800;
			catch_q    <= 14'd717;
			lim_q      <= 15'd2560;
			integ_q    <= '0;
			last_q     <= '0;
		end else begin
			state_q <= state_n;
			if (mul_start || div_start) begin
				run_q <= 1'b1;
			end else if (mul_done || div_done) begin
				run_q <= 1'b0;
			end
			if (accept) begin
				primed_q <= 1'b1;
			end
			if (state_q == ST_OUT && (!m_tvalid_q || m_axis_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == ST_SEL) begin
				integ_q <= bal_n ? integ_n : '0;
				last_q  <= bal_n ? 16'(err17) : '0;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PROP_GAIN:     kp_q    <= cfg_wdata;
					REG_INTEG_GAIN:    ki_q    <= cfg_wdata;
					REG_DERIV_GAIN:    kd_q    <= cfg_wdata;
					REG_ARM_GAIN:      ka_q    <= cfg_wdata;
					REG_ARM_DAMP_GAIN: kad_q   <= cfg_wdata;
					REG_PUMP_GAIN:     kpump_q <= cfg_wdata;
					REG_CATCH_ANGLE:   catch_q <= cfg_wdata[13:0];
					REG_DRIVE_LIMIT:   lim_q   <= cfg_wdata[14:0];
					default:           kp_q    <= kp_q;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			arm_q  <= signed'(s_axis_tdata[15:0]);
			raw_q  <= signed'(s_axis_tdata[47:16]);
			aspd_q <= signed'(s_axis_tdata[63:48]);
			ps_q   <= signed'(s_axis_tdata[79:64]);
		end
		if (state_q == ST_OUT && (!m_tvalid_q || m_axis_tready)) begin
			dv_q   <= v_q;
			mode_q <= bal_q;
		end
		unique case (state_q)
			ST_WRAP: if (div_done) alpha_q <= alpha_n;
			ST_SEL: begin
				bal_q  <= bal_n;
				cneg_q <= amag > 14'(HALF_PI_Q12);
				x_q    <= {cm, 2'b00};
				acc_q  <= '0;
				tix_q  <= '0;
			end
			ST_COS_SQ: if (mul_done) y_q <= mul_p[29:14];
			ST_COS_D1, ST_COS_D2, ST_COS_D3:
				if (div_done) t_q <= 15'(ONE_Q14) - div_quot[14:0];
			ST_COS_M2, ST_COS_M3, ST_EN_SQ: if (mul_done) prod_q <= mul_p;
			ST_COS_M4: if (mul_done) c_q <= cneg_q ? -tt : tt;
			ST_EN_K: if (mul_done) acc_q <= ACC_W'(mul_p);
			ST_EN_P: if (mul_done) begin
				e24_q  <= E24_W'((acc_q - ACC_W'(mul_p)) >>> 16);
				acc_q  <= '0;
				pneg_q <= ps_q[15] != c_q[16];
			end
			ST_TERM: if (mul_done) begin
				acc_q <= acc_n;
				tix_q <= tix_q + 3'd1;
			end
			ST_ROUND: if (div_done) begin
				if (OUTPUT_SIGN == 0) begin
					v_q <= '0;
				end else begin
					v_q <= out_neg ? -16'(qc) : 16'(qc);
				end
			end
			default: tix_q <= tix_q;
		endcase
	end

	psbc_smul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.p     (mul_p)
	);

	psbc_sdiv #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = dv_q;
	assign m_axis_tuser  = mode_q;

	`PSBC_ASSERT_IMPL(a_idle_no_run, state_q == ST_IDLE, !run_q)
	`PSBC_ASSERT_IMPL(a_done_requested, mul_done || div_done, run_q)
	`PSBC_ASSERT(a_one_unit, !(mul_done && div_done))
	`PSBC_ASSERT_NEXT(a_primed_starts, accept && primed_q, state_q == ST_WRAP)
endmodule

FILE: sim/pendulum_swingup_balance_control_tb.sv
// Testbench: pendulum swing-up/balance controller against a cycle-free predictor
module pendulum_swingup_balance_control_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import psbc_pkg::*;

	localparam int LIMIT_CYCLES = 4000000;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES  = 4000;

	typedef struct {
		logic signed [15:0] drive;
		logic               bal;
	} drive_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;

	pendulum_swingup_balance_control uut (.*);

	// controller state mirror
	logic [15:0] g_prop, g_integ, g_deriv, g_arm, g_damp, g_pump;
	logic [13:0] g_catch;
	logic [14:0] g_limit;
	longint      integ_acc;
	longint      prev_err;
	bit          primed;

	drive_cmd_t  cmd_q[$];
	int          errors = 0;
	int          cycles = 0;
	int          rx_count = 0;
	int          hold_req = 0;
	int          rx_seen;
	int          hold_seen;
	int          rx_hold;
	int          rx_wait;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("** pendulum_swingup_balance_control: FAILED **");
			$finish;
		end
	end

	function automatic longint cos_q14(longint a);
		longint mag, x, y, t;
		bit neg;
		mag = a < 0 ? -a : a;
		neg = 0;
		if (mag > HALF_PI_Q12) begin
			mag = PI_Q12 - mag;
			neg = 1;
		end
		x = mag * 4;
		y = (x * x) / ONE_Q14;
		t = ONE_Q14 - y / COS_DIV1;
		t = ONE_Q14 - (y * t) / COS_DIV2;
		t = ONE_Q14 - (y * t) / COS_DIV3;
		t = ONE_Q14 - (y * t) / (2 * ONE_Q14);
		return neg ? -t : t;
	endfunction

	function automatic longint div_round(longint num, longint den);
		if (num < 0)
			return -((-num + den / 2) / den);
		return (num + den / 2) / den;
	endfunction

	// returns 1 when the sample produces a command
	function automatic bit predict_drive(logic signed [15:0] arm, logic signed [31:0] raw,
			logic signed [15:0] aspd, logic signed [15:0] pspd, output drive_cmd_t cmd);
		longint alpha, mag, acc, v, err, c, e40, e24, pump, lim;
		if (!primed) begin
			primed = 1;
			return 0;
		end
		alpha = (longint'(raw) - ANGLE_OFFSET_DEF + PI_Q12) % TWO_PI_Q12;
		if (alpha < 0)
			alpha += TWO_PI_Q12;
		alpha -= PI_Q12;
		mag = alpha < 0 ? -alpha : alpha;
		if (mag <= longint'(g_catch)) begin
			err = -alpha;
			integ_acc = integ_acc + err + prev_err;
			if (integ_acc > INTEG_LIMIT) integ_acc = INTEG_LIMIT;
			if (integ_acc < -INTEG_LIMIT) integ_acc = -INTEG_LIMIT;
			acc = longint'(g_prop) * err * 2000 + longint'(g_integ) * integ_acc
				- longint'(g_deriv) * pspd * 32000 - longint'(g_arm) * arm * 2000
				- longint'(g_damp) * aspd * 32000;
			prev_err = err;
			v = div_round(acc * OUTPUT_SIGN_DEF, BAL_DIV);
			cmd.bal = 1;
		end else begin
			c = cos_q14(alpha);
			integ_acc = 0;
			prev_err = 0;
			e40 = longint'(KINETIC_COEF_DEF) * pspd * pspd
				+ longint'(POTENTIAL_COEF_DEF) * (c - ONE_Q14) * 1024;
			e24 = e40 >>> 16;
			pump = longint'(g_pump) * e24 * 25;
			if ((pspd < 0) != (c < 0))
				pump = -pump;
			acc = -pump + longint'(g_arm) * arm * 6400 + longint'(g_damp) * aspd * 1024;
			v = div_round(acc * OUTPUT_SIGN_DEF, SWING_DIV);
			cmd.bal = 0;
		end
		lim = longint'(g_limit);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		cmd.drive = v[15:0];
		return 1;
	endfunction

	// receiver: per-command stall, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_seen = 0;
			hold_seen = 0;
			rx_hold = 0;
			rx_wait = 0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_count != rx_seen) begin
				rx_seen = rx_count;
				rx_wait = no_idle ? 0 : $urandom_range(0, 16);
			end
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold = rx_hold - 1;
			end else if (rx_wait > 0) begin
				m_axis_tready <= 1'b0;
				rx_wait = rx_wait - 1;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		drive_cmd_t exp_cmd;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			rx_count++;
			if (cmd_q.size() == 0) begin
				$display("%0t: unexpected transfer drive=%0d bal=%0d", $time,
					$signed(m_axis_tdata), m_axis_tuser[0]);
				errors++;
			end else begin
				exp_cmd = cmd_q.pop_front();
				if (m_axis_tdata !== exp_cmd.drive) begin
					$display("%0t: drive_voltage expected %0d actual %0d", $time,
						exp_cmd.drive, $signed(m_axis_tdata));
					errors++;
				end
				if (m_axis_tuser[0] !== exp_cmd.bal) begin
					$display("%0t: balancing expected %0d actual %0d", $time,
						exp_cmd.bal, m_axis_tuser[0]);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PROP_GAIN:     g_prop = val;
			REG_INTEG_GAIN:    g_integ = val;
			REG_DERIV_GAIN:    g_deriv = val;
			REG_ARM_GAIN:      g_arm = val;
			REG_ARM_DAMP_GAIN: g_damp = val;
			REG_PUMP_GAIN:     g_pump = val;
			REG_CATCH_ANGLE:   g_catch = val[13:0];
			REG_DRIVE_LIMIT:   g_limit = val[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [15:0] p, logic [15:0] i, logic [15:0] d, logic [15:0] a,
			logic [15:0] ad, logic [15:0] pu, logic [15:0] ca, logic [15:0] dl);
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_ARM_GAIN, a);
		write_reg(REG_ARM_DAMP_GAIN, ad);
		write_reg(REG_PUMP_GAIN, pu);
		write_reg(REG_CATCH_ANGLE, ca);
		write_reg(REG_DRIVE_LIMIT, dl);
	endtask

	task automatic wait_idle();
		while (cmd_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one sample transfer; valid stays high across back-to-back samples
	task automatic send_sample(logic signed [15:0] arm, logic signed [31:0] raw,
			logic signed [15:0] aspd, logic signed [15:0] pspd);
		int gap;
		drive_cmd_t cmd;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else
			@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pspd, aspd, raw, arm};
		do @(posedge clk); while (!s_axis_tready);
		if (predict_drive(arm, raw, aspd, pspd, cmd))
			cmd_q = {cmd_q, cmd};
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_random(int near_pct);
		logic signed [31:0] raw;
		int k;
		if ($urandom_range(0, 99) < near_pct) begin
			k = $signed($urandom_range(0, 160000)) - 80000;
			raw = k * TWO_PI_Q12 + ($signed($urandom_range(0, 2 * g_catch + 2))
				- int'(g_catch) - 1);
		end else
			raw = $urandom;
		send_sample(16'($urandom), raw, 16'($urandom), 16'($urandom));
	endtask

	task automatic test_first_sample();
		send_sample(16'sd100, 32'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd100, 32'sd0, 16'sd0, 16'sd0);
		end_burst();
		wait_idle();
	endtask

	task automatic test_directed();
		send_sample(16'sh7fff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000, 32'sh80000000, 16'sh8000, 16'sh8000);
		send_sample(16'sd0, 32'sd717, 16'sd0, 16'sd0);
		send_sample(16'sd0, -32'sd717, 16'sd0, 16'sd0);
		send_sample(16'sd0, 32'sd718, 16'sd0, -16'sd1);
		send_sample(16'sd0, 32'sd12868, 16'sd0, 16'sd0);
		send_sample(16'sd0, 32'sd6434, 16'sd1, 16'sd300);
		send_sample(16'sd0, 32'sd6435, -16'sd1, -16'sd300);
		send_sample(-16'sd5, -32'sd25736, 16'sd50, 16'sd0);
		send_sample(16'sd5, 32'sd25737, -16'sd50, 16'sh8000);
		send_sample(16'sh7fff, 32'sd0, 16'sh7fff, 16'sh7fff);
		end_burst();
		wait_idle();
	endtask

	task automatic test_register_extremes();
		// catch angle beyond pi: every sample balances
		write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'h3fff, 16'h7fff);
		for (int n = 0; n < 6; n++)
			send_random(0);
		send_sample(16'sd0, 32'sd12868, 16'sd0, 16'sd0);
		end_burst();
		wait_idle();
		write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000);
		for (int n = 0; n < 6; n++)
			send_random(50);
		send_sample(16'sd0, 32'sd0, 16'sd0, 16'sd0);
		end_burst();
		wait_idle();
		write_all(16'd40960, 16'd2048, 16'd410, 16'd205, 16'd41, 16'd12800,
			16'd12868, 16'd2560);
		send_sample(16'sd0, 32'sd12868, 16'sd0, 16'sd0);
		send_sample(16'sd0, -32'sd12868, 16'sd0, 16'sd0);
		end_burst();
		wait_idle();
	endtask

	task automatic test_backpressure();
		hold_req++;
		for (int n = 0; n < 20; n++)
			send_random(50);
		end_burst();
		wait_idle();
	endtask

	task automatic test_no_idle();
		no_idle = 1;
		for (int n = 0; n < 60; n++)
			send_random(50);
		end_burst();
		wait_idle();
		no_idle = 0;
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 9; phase++) begin
			write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)),
				16'($urandom_range(0, 4000)), 16'($urandom_range(0, 600)), 16'($urandom),
				16'($urandom_range(0, 13000)), 16'($urandom));
			for (int n = 0; n < 200; n++)
				send_random(60);
			end_burst();
			wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_PROP_GAIN;
		cfg_wdata = '0;
		no_idle = 0;
		g_prop = 16'd40960; g_integ = 16'd2048; g_deriv = 16'd410; g_arm = 16'd205;
		g_damp = 16'd41; g_pump = 16'd12800; g_catch = 14'd717; g_limit = 15'd2560;
		integ_acc = 0;
		prev_err = 0;
		primed = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_sample();
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_no_idle();
		test_random();

		if (errors == 0)
			$display("** pendulum_swingup_balance_control: PASSED **");
		else
			$display("** pendulum_swingup_balance_control: FAILED **");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/psbc_pkg.sv
rtl/core/psbc_smul.sv
rtl/core/psbc_sdiv.sv
rtl/core/pendulum_swingup_balance_control.sv
sim/pendulum_swingup_balance_control_tb.sv
